[rtl/gbl_pkg.sv]
// Shared types and constants for the border-normalized 5x5 blur.
package gbl_pkg;
   localparam int MaxWidthDefault = 1024;
   localparam int RowSlots        = 6;
   localparam int MaxHeight       = 4096;
   localparam int RowW            = 13;
   localparam int CmdPixel        = 0;
   localparam int CmdDrain        = 1;
   localparam int CfgWidthIdx     = 0;
   localparam int CfgHeightIdx    = 1;

   // Job handed from the front to the back: one output pixel.
   typedef struct packed {
      logic [RowW-1:0] row;
      logic [13:0]     col;
      logic [13:0]     width;
      logic [RowW-1:0] height;
      logic            last;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FETCH,
      BK_DIV,
      BK_OUT
   } bk_state_type;

   function automatic logic [3:0] kern_weight(input logic [2:0] r, input logic [2:0] c);
      logic [2:0] rr;
      logic [2:0] cc;
      rr = (r > 3'd2) ? 3'd4 - r : r;
      cc = (c > 3'd2) ? 3'd4 - c : c;
      case ({rr[1:0], cc[1:0]})
         4'b0000: kern_weight = 4'd2;
         4'b0001: kern_weight = 4'd4;
         4'b0010: kern_weight = 4'd5;
         4'b0100: kern_weight = 4'd4;
         4'b0101: kern_weight = 4'd9;
         4'b0110: kern_weight = 4'd12;
         4'b1000: kern_weight = 4'd5;
         4'b1001: kern_weight = 4'd12;
         4'b1010: kern_weight = 4'd15;
         default: kern_weight = 4'd0;
      endcase
   endfunction
endpackage

[rtl/gbl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gbl_ram #(
   parameter int Width = 8,
   parameter int Depth = 6144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/gbl_front.sv]
// Front end: counts raster position, writes pixels, issues output jobs.
module gbl_front import gbl_pkg::*; #(
   parameter int MaxWidth = MaxWidthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_cmd,
   input  logic [13:0]                 eff_width,
   input  logic [RowW-1:0]             eff_height,
   output logic                        wr_en,
   output logic [$clog2(MaxWidth)-1:0] wr_col,
   output logic [2:0]                  wr_slot,
   output logic                        job_valid,
   input  logic                        job_ready,
   output job_type                     job
);
   logic [RowW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [13:0]     in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [2:0]      slot_ff, slot_in;
   logic [RowW-1:0] ir, orow;
   logic [13:0]     ic, oc;
   logic [2:0]      sl;
   logic            wrap, emit, fire;

   assign in_ready = job_ready;
   assign fire     = in_valid & in_ready;

   always_comb begin
      wrap = (in_row_ff >= eff_height) && (out_row_ff >= eff_height);
      ir   = wrap ? '0 : in_row_ff;
      ic   = wrap ? '0 : in_col_ff;
      orow = wrap ? '0 : out_row_ff;
      oc   = wrap ? '0 : out_col_ff;
      sl   = wrap ? '0 : slot_ff;
      wr_en  = 1'b0;
      emit   = 1'b0;
      in_row_in = ir; in_col_in = ic; out_row_in = orow; out_col_in = oc; slot_in = sl;
      if (in_cmd == 1'(CmdPixel)) begin
         if (ir < eff_height) begin
            wr_en = fire && (ic < 14'(MaxWidth));
            if (ic + 14'd1 >= eff_width) begin
               in_col_in = '0;
               in_row_in = ir + 1'b1;
               slot_in   = (sl == 3'(RowSlots - 1)) ? '0 : sl + 3'd1;
            end else begin
               in_col_in = ic + 14'd1;
            end
            emit = (orow < eff_height) && ({1'b0, orow} + 14'd3 <= {1'b0, ir});
         end
      end else begin
         emit = (ir >= eff_height) && (orow < eff_height);
      end
      if (emit) begin
         if (oc + 14'd1 >= eff_width) begin
            out_col_in = '0;
            out_row_in = orow + 1'b1;
         end else begin
            out_col_in = oc + 14'd1;
         end
      end
      job.row    = orow;
      job.col    = oc;
      job.width  = eff_width;
      job.height = eff_height;
      job.last   = (out_row_in >= eff_height);
      job_valid  = fire & emit;
   end

   assign wr_col  = ic[$clog2(MaxWidth)-1:0];
   assign wr_slot = sl;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff <= '0; in_col_ff <= '0; out_row_ff <= '0; out_col_ff <= '0;
         slot_ff <= '0;
      end else if (fire) begin
         in_row_ff <= in_row_in; in_col_ff <= in_col_in;
         out_row_ff <= out_row_in; out_col_ff <= out_col_in;
         slot_ff <= slot_in;
      end
   end
endmodule

[rtl/gbl_queue.sv]
// Two-entry job queue between front and back.
module gbl_queue import gbl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    has_room,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);
   job_type    mem_ff [2];
   logic       rd_ff, wr_ff;
   logic [1:0] cnt_ff;

   assign has_room  = (cnt_ff != 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[rtl/gbl_back.sv]
// Back end: fetches the 5x5 window, accumulates, divides, presents the word.
module gbl_back import gbl_pkg::*; #(
   parameter int MaxWidth = MaxWidthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  job_type                     job,
   output logic                        job_pop,
   output logic [2:0]                  rd_slot,
   output logic [$clog2(MaxWidth)-1:0] rd_col,
   output logic                        rd_lock,
   input  logic [7:0]                  rd_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [7:0]                  out_value,
   output logic                        out_last
);
   bk_state_type st_ff, st_in;
   job_type   job_ff;
   logic [4:0]  tap_ff, tap_in;       // window index being addressed
   logic        pend_ff;              // read data of previous tap valid
   logic [2:0]  ptr_ff, pc_ff;        // row/col of previous tap
   logic        pin_ff;               // previous tap in image
   logic [15:0] acc_ff;
   logic [7:0]  wsum_ff;
   logic [15:0] rem_ff;
   logic [8:0]  quo_ff;
   logic [3:0]  dstep_ff;
   logic [7:0]  val_ff;
   logic        last_ff;
   logic [2:0]  tr, tc;
   logic [8:0]  tap_mul;
   logic signed [RowW+1:0] rr;
   logic signed [15:0]     cc;
   logic        tin;
   logic [RowW-1:0]  rmod, rq, rrem;
   logic [RowW+13:0] rprod;
   logic [2:0]  slot_calc;
   logic [16:0] trial;
   logic [3:0]  wt;

   // Split the tap index into window row and column: tap * 13 / 64 is tap / 5 here.
   assign tap_mul = 9'(tap_ff) * 9'd13;
   assign tr      = tap_mul[8:6];
   assign tc      = 3'(tap_ff - 5'(tr) * 5'd5);

   // Row slot = (row + dr) mod 6 by reciprocal multiplication.
   always_comb begin
      rr  = $signed({2'b00, job_ff.row}) + $signed({{(RowW-1){1'b0}}, tr})
            - $signed((RowW+2)'(2));
      cc  = $signed({2'b00, job_ff.col}) + $signed({13'd0, tc}) - 16'sd2;
      tin = (rr >= 0) && (rr < $signed({2'b00, job_ff.height}))
            && (cc >= 0) && (cc < $signed({2'b00, job_ff.width}))
            && (cc < 16'(MaxWidth));
      rmod  = rr[RowW-1:0];
      rprod = (RowW+14)'(rmod) * (RowW+14)'(14'd10923);
      rq    = RowW'(rprod >> 16);
      rrem  = rmod - rq * RowW'(6);
      slot_calc = rrem[2:0];
      wt = kern_weight(ptr_ff, pc_ff);
      trial = {1'b0, rem_ff} - ({9'd0, wsum_ff} << dstep_ff);
   end

   assign rd_slot = slot_calc;
   assign rd_col  = cc[$clog2(MaxWidth)-1:0];
   assign rd_lock = (st_ff == BK_FETCH);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE:  if (job_valid) st_in = BK_FETCH;
         BK_FETCH: if (tap_ff == 5'd25) st_in = BK_DIV;
         BK_DIV:   if (dstep_ff == 4'd0) st_in = BK_OUT;
         BK_OUT:   if (out_ready) st_in = BK_IDLE;
         default:  st_in = BK_IDLE;
      endcase
   end

   always_comb begin
      job_pop   = (st_ff == BK_IDLE) && job_valid;
      out_valid = (st_ff == BK_OUT);
      out_value = val_ff;
      out_last  = last_ff;
      tap_in    = (tap_ff == 5'd25) ? tap_ff : tap_ff + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
      end else begin
         st_ff <= st_in;
      end
      case (st_ff)
         BK_IDLE: begin
            job_ff <= job; tap_ff <= '0; pend_ff <= 1'b0;
            acc_ff <= '0; wsum_ff <= '0; dstep_ff <= 4'd8;
         end
         BK_FETCH: begin
            tap_ff  <= tap_in;
            pend_ff <= (tap_ff != 5'd25);
            ptr_ff <= tr; pc_ff <= tc; pin_ff <= tin;
            if (pend_ff && pin_ff) begin
               acc_ff  <= acc_ff + 16'(wt) * 16'(rd_data);
               wsum_ff <= wsum_ff + 8'(wt);
            end
            if (tap_ff == 5'd25) begin
               rem_ff <= (pend_ff && pin_ff) ? acc_ff + 16'(wt) * 16'(rd_data) : acc_ff;
               quo_ff <= '0;
            end
         end
         BK_DIV: begin
            // Restoring division, one quotient bit a cycle.
            if (!trial[16]) begin
               rem_ff <= trial[15:0];
               quo_ff <= quo_ff | (9'd1 << dstep_ff);
            end
            if (dstep_ff != 4'd0) dstep_ff <= dstep_ff - 4'd1;
            else begin
               val_ff  <= trial[16] ? quo_ff[7:0] : (quo_ff[7:0] | 8'd1);
               last_ff <= job_ff.last;
            end
         end
         default: ;
      endcase
   end
endmodule

[rtl/gauss5x5_border_normalized_blur.sv]
// Top level: border-normalized 5x5 Gaussian blur over a gray raster stream.
// Usage:
//  req_ channel carries one word per raster pixel (tuser = command: 0 pixel,
//  1 drain step); pixels of rows 0..H-1 fill a six-row line store.
//  Output row r appears one word per pixel of input row r+3; after the frame
//  send drain words until rsp_tlast marks the last output pixel.
//  rsp_ channel carries the blurred pixel and tlast on the frame's last one.
//  csr_ channel writes image_width (index 0) and image_height (index 1);
//  write them only while the block is idle (the block does not enforce it).
//  Throughput: a word that yields no output is taken every cycle while the
//  queue is empty and the back end is not reading its window; one that yields
//  an output holds the back end for a pop state, a walk of the 25 window taps
//  through the single line-store read port, a restoring divider and an output
//  state, so the back end works on one such word at a time.
//  The front holds req_tready low while a job waits in the queue or the back
//  end reads its window, so no later pixel overwrites a row still needed;
//  while the back end divides or waits on rsp_tready one job can be parked.
//  Reset clears the front's counters and the queue and returns the back end to idle; the line store is not cleared.
module gauss5x5_border_normalized_blur import gbl_pkg::*; #(
   parameter int MaxWidth = MaxWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_value
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] blurred_value
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);
   localparam int ColW  = $clog2(MaxWidth);
   localparam int Depth = RowSlots * MaxWidth;
   localparam int AddrW = $clog2(Depth);

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [13:0] eff_width;
   logic [RowW-1:0] eff_height;
   logic wr_en, job_push, q_room, q_pop, q_valid, rd_lock;
   logic [ColW-1:0] wr_col, rd_col;
   logic [2:0] wr_slot, rd_slot;
   logic [7:0] rd_data;
   job_type push_job, head_job;
   logic req_ok;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 13'd480;
      end else if (csr_valid) begin
         if (csr_index == 1'(CfgWidthIdx)) width_ff <= csr_data[10:0];
         else height_ff <= csr_data;
      end
   end

   always_comb begin
      eff_width = (width_ff == '0) ? 14'd1 :
                  (14'(width_ff) > 14'(MaxWidth)) ? 14'(MaxWidth) : 14'(width_ff);
      eff_height = (height_ff == '0) ? RowW'(1) :
                   (height_ff > RowW'(MaxHeight)) ? RowW'(MaxHeight) : height_ff;
   end

   // Hold input while a job waits or its window is read: a later pixel may
   // land in a row slot that job still needs.
   assign req_ok = q_room & ~q_valid & ~rd_lock;

   gbl_front #(.MaxWidth(MaxWidth)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(req_tuser),
      .eff_width, .eff_height,
      .wr_en, .wr_col, .wr_slot,
      .job_valid(job_push), .job_ready(req_ok), .job(push_job)
   );

   gbl_ram #(.Width(8), .Depth(Depth)) u_ram (
      .clock,
      .wr_en,
      .wr_addr(AddrW'(wr_slot) * AddrW'(MaxWidth) + AddrW'(wr_col)),
      .wr_data(req_tdata),
      .rd_addr(AddrW'(rd_slot) * AddrW'(MaxWidth) + AddrW'(rd_col)),
      .rd_data
   );

   gbl_queue u_queue (
      .clock, .reset,
      .push(job_push), .push_job, .has_room(q_room),
      .pop(q_pop), .not_empty(q_valid), .head(head_job)
   );

   gbl_back #(.MaxWidth(MaxWidth)) u_back (
      .clock, .reset,
      .job_valid(q_valid), .job(head_job), .job_pop(q_pop),
      .rd_slot, .rd_col, .rd_lock, .rd_data,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_value(rsp_tdata), .out_last(rsp_tlast)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      job_push |-> q_room) else $error("job pushed into full queue");
   a_no_write_in_fetch: assert property (@(posedge clock) disable iff (reset)
      rd_lock |-> !wr_en || !req_tready) else $error("store write during window read");
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
endmodule
